[src/sync_length_checksum_deframer_assert.svh]
// ---------------------------------------------------------------------------
// sync_length_checksum_deframer assertion macros
// Shorthand for the clocked checks at the end of the deframer top level.
// ---------------------------------------------------------------------------
`ifndef SYNC_LENGTH_CHECKSUM_DEFRAMER_ASSERT_SVH
`define SYNC_LENGTH_CHECKSUM_DEFRAMER_ASSERT_SVH

// same-cycle implication, skipped while reset is active
`define SLCD_ASSERT_NOW(lbl, ck, rstn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("slcd check failed");

// next-cycle implication, skipped while reset is active
`define SLCD_ASSERT_NEXT(lbl, ck, rstn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("slcd check failed");

`endif

[src/slcd_pkg.sv]
// ---------------------------------------------------------------------------
// slcd_pkg
// Shared types and constants of the sync/length/checksum deframer.
// ---------------------------------------------------------------------------
package slcd_pkg;

	localparam logic [7:0] SYNC_BYTE    = 8'h24;
	localparam int         LEN_HI_SHIFT = 8;
	localparam int         LIMIT_W      = 10;
	localparam int         OFFSET_W     = 10;

	// register map (word index)
	localparam logic       REG_STORE_LIMIT = 1'b0;
	localparam logic [LIMIT_W-1:0] STORE_LIMIT_RST = 10'd1023;

	typedef enum logic [2:0] {
		PH_HUNT,
		PH_CHECK,
		PH_LEN_LO,
		PH_LEN_HI,
		PH_DATA
	} phase_t;

	typedef struct packed {
		logic                has_payload;
		logic [7:0]          payload_byte;
		logic [OFFSET_W-1:0] payload_offset;
		logic                kept;
		logic                frame_end;
		logic                frame_good;
		logic [LIMIT_W-1:0]  frame_length;
	} result_t;

endpackage

[src/sync_length_checksum_deframer.sv]
// ---------------------------------------------------------------------------
// sync_length_checksum_deframer
// Hunts for sync, checks an additive checksum and emits framed payload bytes.
//
//   channel   dir  beat
//   s_axis    in   one received byte
//   m_axis    out  payload byte / frame close, zero or one per input beat
//   apb       cfg  store_limit at address 0
//
// One byte per cycle sustained while the output is not stalled; an accepted
// byte is held in the input register and its result is registered in the
// output register. The phase FSM and the running-sum adder sit between them.
// A stalled output register holds the input register, which then drops tready.
// Reset returns the parser to hunting and store_limit to 1023.
// ---------------------------------------------------------------------------
`include "sync_length_checksum_deframer_assert.svh"

module sync_length_checksum_deframer #(
	parameter int MAX_FRAME_BYTES = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	// slave side
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
	// master side
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [7:0] payload_byte, [17:8] payload_offset,
	                                    // [27:18] frame_length, [31:28] zero
	output logic        m_axis_tlast,   // frame_end
	output logic [2:0]  m_axis_tuser,   // [0] has_payload, [1] kept, [2] frame_good
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic                          v_s1;
	logic [7:0]                    byte_s1;
	logic                          out_valid_q;
	slcd_pkg::result_t             res_q;
	slcd_pkg::result_t             res;
	logic                          res_valid;
	logic                          adv;
	logic                          step;
	logic [slcd_pkg::LIMIT_W-1:0]  store_limit;

	assign pready        = 1'b1;
	assign adv           = !out_valid_q || m_axis_tready;
	assign step          = v_s1 && adv;
	assign s_axis_tready = !v_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			v_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
		end
	end

	slcd_cfg u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.pready      (pready),
		.prdata      (prdata),
		.store_limit (store_limit)
	);

	slcd_core #(
		.MAX_FRAME_BYTES (MAX_FRAME_BYTES)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.rx_byte     (byte_s1),
		.store_limit (store_limit),
		.res_valid   (res_valid),
		.res         (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= step && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res_valid) begin
			res_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {4'b0000, res_q.frame_length, res_q.payload_offset,
		res_q.payload_byte};
	assign m_axis_tlast  = res_q.frame_end;
	assign m_axis_tuser  = {res_q.frame_good, res_q.kept, res_q.has_payload};

	// a beat without payload only ever closes an empty frame
	`SLCD_ASSERT_NOW(a_empty_closes, clk, arst_n,
		out_valid_q && !res_q.has_payload,
		res_q.frame_end && res_q.frame_length == '0)
	// mid-frame beats carry no frame status
	`SLCD_ASSERT_NOW(a_mid_no_status, clk, arst_n,
		out_valid_q && !res_q.frame_end,
		!res_q.frame_good && res_q.frame_length == '0)
	// a held input beat is not lost while the output stalls
	`SLCD_ASSERT_NEXT(a_s1_hold, clk, arst_n,
		v_s1 && !adv,
		v_s1 && $stable(byte_s1))

endmodule

[src/slcd_cfg.sv]
// ---------------------------------------------------------------------------
// slcd_cfg
// APB register file: holds store_limit.
// ---------------------------------------------------------------------------
module slcd_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [2:0]                     paddr,
	input  logic [31:0]                    pwdata,
	input  logic                           pready,
	output logic [31:0]                    prdata,
	output logic [slcd_pkg::LIMIT_W-1:0]   store_limit
);

	logic                          wr_en;
	logic                          reg_idx;
	logic [slcd_pkg::LIMIT_W-1:0]  limit_q;

	assign reg_idx = paddr[2];
	assign wr_en   = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= slcd_pkg::STORE_LIMIT_RST;
		end else if (wr_en && reg_idx == slcd_pkg::REG_STORE_LIMIT) begin
			limit_q <= pwdata[slcd_pkg::LIMIT_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (reg_idx == slcd_pkg::REG_STORE_LIMIT) begin
			prdata = 32'(limit_q);
		end
	end

	assign store_limit = limit_q;

endmodule

[src/slcd_core.sv]
// ---------------------------------------------------------------------------
// slcd_core
// Frame parser: phase FSM, checksum and length state, per-byte result.
// ---------------------------------------------------------------------------
module slcd_core #(
	parameter int MAX_FRAME_BYTES = 1024
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           step,
	input  logic [7:0]                     rx_byte,
	input  logic [slcd_pkg::LIMIT_W-1:0]   store_limit,
	output logic                           res_valid,
	output slcd_pkg::result_t              res
);

	localparam int LW = $clog2(MAX_FRAME_BYTES);
	localparam int WW = LW + 8;
	localparam int CW = (LW > slcd_pkg::LIMIT_W) ? LW : slcd_pkg::LIMIT_W;
	localparam logic [8:0] HI_BOUND = 9'(MAX_FRAME_BYTES / 256);

	slcd_pkg::phase_t phase_q, phase_d;
	logic [7:0]       exp_sum_q, exp_sum_d;
	logic [7:0]       run_sum_q, run_sum_d;
	logic [LW-1:0]    len_q, len_d;
	logic [LW-1:0]    off_q, off_d;

	logic             hi_over;
	logic [LW-1:0]    len_join;
	logic [7:0]       sum_add;
	logic [LW:0]      off_inc;
	logic             last_byte;
	logic [CW-1:0]    off_cmp;
	logic [CW-1:0]    len_cmp;
	logic [CW-1:0]    limit_cmp;

	assign hi_over   = 9'(rx_byte) >= HI_BOUND;
	assign len_join  = LW'((WW'(rx_byte) << slcd_pkg::LEN_HI_SHIFT) | WW'(len_q));
	assign sum_add   = run_sum_q + rx_byte;
	assign off_inc   = (LW+1)'(off_q) + 1'b1;
	assign last_byte = off_inc >= (LW+1)'(len_q);
	assign off_cmp   = CW'(off_q);
	assign len_cmp   = CW'(len_q);
	assign limit_cmp = CW'(store_limit);

	// next phase
	always_comb begin
		phase_d = phase_q;
		case (phase_q)
			slcd_pkg::PH_HUNT: begin
				if (rx_byte == slcd_pkg::SYNC_BYTE) begin
					phase_d = slcd_pkg::PH_CHECK;
				end
			end
			slcd_pkg::PH_CHECK:  phase_d = slcd_pkg::PH_LEN_LO;
			slcd_pkg::PH_LEN_LO: phase_d = slcd_pkg::PH_LEN_HI;
			slcd_pkg::PH_LEN_HI: begin
				if (hi_over || len_join == '0) begin
					phase_d = slcd_pkg::PH_HUNT;
				end else begin
					phase_d = slcd_pkg::PH_DATA;
				end
			end
			slcd_pkg::PH_DATA: begin
				if (last_byte) begin
					phase_d = slcd_pkg::PH_HUNT;
				end
			end
			default: phase_d = slcd_pkg::PH_HUNT;
		endcase
	end

	// result and datapath updates
	always_comb begin
		res       = '0;
		res_valid = 1'b0;
		exp_sum_d = exp_sum_q;
		run_sum_d = run_sum_q;
		len_d     = len_q;
		off_d     = off_q;
		case (phase_q)
			slcd_pkg::PH_CHECK: begin
				exp_sum_d = rx_byte;
			end
			slcd_pkg::PH_LEN_LO: begin
				len_d     = LW'(rx_byte);
				run_sum_d = slcd_pkg::SYNC_BYTE + rx_byte;
			end
			slcd_pkg::PH_LEN_HI: begin
				if (!hi_over) begin
					run_sum_d = sum_add;
					len_d     = len_join;
					off_d     = '0;
					// empty frame closes right here
					if (len_join == '0) begin
						res_valid      = 1'b1;
						res.frame_end  = 1'b1;
						res.frame_good = sum_add == exp_sum_q;
					end
				end
			end
			slcd_pkg::PH_DATA: begin
				run_sum_d          = sum_add;
				res_valid          = 1'b1;
				res.has_payload    = 1'b1;
				res.payload_byte   = rx_byte;
				res.payload_offset = slcd_pkg::OFFSET_W'(off_q);
				res.kept           = off_cmp < limit_cmp;
				if (last_byte) begin
					res.frame_end    = 1'b1;
					res.frame_good   = sum_add == exp_sum_q;
					res.frame_length = slcd_pkg::LIMIT_W'((len_cmp < limit_cmp) ?
						len_cmp : limit_cmp);
				end else begin
					off_d = off_inc[LW-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= slcd_pkg::PH_HUNT;
			exp_sum_q <= '0;
			run_sum_q <= '0;
			len_q     <= '0;
			off_q     <= '0;
		end else if (step) begin
			phase_q   <= phase_d;
			exp_sum_q <= exp_sum_d;
			run_sum_q <= run_sum_d;
			len_q     <= len_d;
			off_q     <= off_d;
		end
	end

endmodule
